// ===== rtl/lorenz_euler_integrator_defines.svh =====
// Assertion macros used by the Lorenz integrator top level.
`ifndef LORENZ_EULER_INTEGRATOR_DEFINES_SVH
`define LORENZ_EULER_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LEI_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LEI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lorenz_pkg.sv =====
// Shared types and constants of the Lorenz Euler integrator.
package lorenz_pkg;

    localparam int DP_WIDTH    = 64;
    localparam int FRAC_BITS   = 24;
    localparam int DIGIT_WIDTH = 4;
    localparam int NUM_DIGITS  = DP_WIDTH / DIGIT_WIDTH;
    localparam int CNT_WIDTH   = $clog2(NUM_DIGITS);
    localparam int OUT_WIDTH   = 32;

    typedef logic signed [DP_WIDTH-1:0] dp_t;

    localparam dp_t DP_MAX = {1'b0, {(DP_WIDTH-1){1'b1}}};
    localparam dp_t DP_MIN = {1'b1, {(DP_WIDTH-1){1'b0}}};
    localparam dp_t ONE_Q  = dp_t'(1) <<< FRAC_BITS;

    typedef enum logic [2:0] {
        REG_SIGMA,
        REG_BETA,
        REG_RHO,
        REG_TIME_STEP,
        REG_START_X,
        REG_START_Y,
        REG_START_Z
    } cfg_index_t;

    typedef struct packed {
        logic        [30:0] sigma;
        logic        [30:0] beta;
        logic        [30:0] rho;
        logic        [24:0] time_step;
        logic        [31:0] start_x;
        logic        [31:0] start_y;
        logic        [31:0] start_z;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sigma:     31'd167772160,
        beta:      31'd44738124,
        rho:       31'd469762048,
        time_step: 25'd16777,
        start_x:   32'd16777216,
        start_y:   32'd16777216,
        start_z:   32'd16777216
    };

    typedef struct packed {
        logic [OUT_WIDTH-1:0] pos_x;
        logic [OUT_WIDTH-1:0] pos_y;
        logic [OUT_WIDTH-1:0] pos_z;
        logic                 clipped;
    } point_t;

    typedef struct packed {
        logic start;
        dp_t  a;
        dp_t  b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
        dp_t  product;
    } mul_rsp_t;

endpackage

// ===== rtl/lorenz_euler_integrator.sv =====
// Lorenz attractor explicit Euler integrator, signed Q8.24, top level.
//
// Input channel (in_valid/in_ready, restart): a beat with restart high
// loads the configured start point (saturated to WORD_WIDTH bits) and
// emits it; restart low advances the point by one Euler step.
// Output channel (out_valid/out_ready): one beat per input beat carrying
// pos_x, pos_y, pos_z and clipped (set when any value saturated).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while the block is idle.
// Order: a restart beat passes from the input through the sequencer's
// S_DONE state to the output register. A step beat first runs seven
// products through one digit-serial multiplier taking 4 bits of its
// second operand per cycle, plus two adder states, before S_DONE.
// A new input beat is accepted only while the sequencer is idle.
// The output register holds a finished beat while the receiver stalls;
// the next input beat is taken meanwhile, and its result waits in the
// sequencer until the output register frees up.
// Reset: point and registers return to their defaults (1.0 start point,
// sigma 10, beta about 2.6666, rho 28, dt about 0.001); output empties.
`include "lorenz_euler_integrator_defines.svh"

module lorenz_euler_integrator
#(
    parameter int WORD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic        clipped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lorenz_pkg::cfg_t   cfg_reg, cfg_next;
    logic               out_valid_reg, out_valid_next;
    lorenz_pkg::point_t out_point_reg, out_point_next;

    logic               seq_idle;
    logic               res_valid;
    logic               res_ready;
    lorenz_pkg::point_t res;

    lorenz_seq
    #(
        .WORD_WIDTH (WORD_WIDTH)
    )
    u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .restart   (restart),
        .cfg       (cfg_reg),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign in_ready  = seq_idle;
    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (lorenz_pkg::cfg_index_t'(cfg_index))
                lorenz_pkg::REG_SIGMA:     cfg_next.sigma     = cfg_data[30:0];
                lorenz_pkg::REG_BETA:      cfg_next.beta      = cfg_data[30:0];
                lorenz_pkg::REG_RHO:       cfg_next.rho       = cfg_data[30:0];
                lorenz_pkg::REG_TIME_STEP: cfg_next.time_step = cfg_data[24:0];
                lorenz_pkg::REG_START_X:   cfg_next.start_x   = cfg_data;
                lorenz_pkg::REG_START_Y:   cfg_next.start_y   = cfg_data;
                lorenz_pkg::REG_START_Z:   cfg_next.start_z   = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_point_next = out_point_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_point_next = res;
        end
        else if (out_ready)
        begin
            // drop the beat once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= lorenz_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_point_reg <= out_point_next;
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = out_point_reg.pos_x;
    assign pos_y     = out_point_reg.pos_y;
    assign pos_z     = out_point_reg.pos_z;
    assign clipped   = out_point_reg.clipped;

    `LEI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
    `LEI_ASSERT_IMPLY(a_ready_not_pending, in_ready, !res_valid, "idle with a result pending")
    `LEI_ASSERT_NEXT(a_commit_fills_out, res_valid && res_ready, out_valid, "result beat lost")

endmodule

// ===== rtl/lorenz_mul.sv =====
// Digit-serial signed Q40.24 multiplier: one 4-bit digit of b per cycle, floor and saturate.
module lorenz_mul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lorenz_pkg::mul_req_t req,
    output lorenz_pkg::mul_rsp_t rsp
);

    localparam int ACC_WIDTH  = lorenz_pkg::DP_WIDTH + lorenz_pkg::DIGIT_WIDTH + 2;
    localparam int PP_WIDTH   = lorenz_pkg::DP_WIDTH + lorenz_pkg::DIGIT_WIDTH + 1;
    localparam int FULL_WIDTH = ACC_WIDTH + lorenz_pkg::DP_WIDTH;
    localparam int Q_TOP      = lorenz_pkg::DP_WIDTH - 1 + lorenz_pkg::FRAC_BITS;
    localparam logic [lorenz_pkg::CNT_WIDTH-1:0] LAST_DIGIT =
        lorenz_pkg::CNT_WIDTH'(lorenz_pkg::NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_FIN
    } mstate_t;

    typedef logic signed [ACC_WIDTH-1:0] acc_t;
    typedef logic signed [PP_WIDTH-1:0]  pp_t;

    mstate_t                             state_reg, state_next;
    logic [lorenz_pkg::CNT_WIDTH-1:0]    cnt_reg, cnt_next;
    logic                                done_reg, done_next;
    logic                                ovf_reg, ovf_next;
    lorenz_pkg::dp_t                     product_reg, product_next;

    lorenz_pkg::dp_t                     a_reg, a_next;
    logic [lorenz_pkg::DP_WIDTH-1:0]     b_reg, b_next;
    acc_t                                h_reg, h_next;
    logic [lorenz_pkg::DP_WIDTH-1:0]     l_reg, l_next;

    logic [lorenz_pkg::DIGIT_WIDTH-1:0]  digit;
    logic signed [lorenz_pkg::DIGIT_WIDTH:0] digit_s;
    pp_t                                 pp;
    acc_t                                sum;
    logic [FULL_WIDTH-1:0]               full;
    logic [FULL_WIDTH-1-Q_TOP:0]         q_high;

    always_comb
    begin
        digit   = b_reg[lorenz_pkg::DIGIT_WIDTH-1:0];
        // top digit carries the sign of b
        digit_s = (cnt_reg == LAST_DIGIT) ? {digit[lorenz_pkg::DIGIT_WIDTH-1], digit}
                                          : {1'b0, digit};
        pp      = pp_t'(a_reg) * pp_t'(digit_s);
        sum     = h_reg + acc_t'(pp);
        full    = {h_reg, l_reg};
        q_high  = full[FULL_WIDTH-1:Q_TOP];
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        ovf_next     = ovf_reg;
        product_next = product_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        h_next       = h_reg;
        l_next       = l_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    h_next     = '0;
                    l_next     = '0;
                    cnt_next   = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                h_next   = sum >>> lorenz_pkg::DIGIT_WIDTH;
                l_next   = {sum[lorenz_pkg::DIGIT_WIDTH-1:0],
                            l_reg[lorenz_pkg::DP_WIDTH-1:lorenz_pkg::DIGIT_WIDTH]};
                b_next   = b_reg >> lorenz_pkg::DIGIT_WIDTH;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIGIT)
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:
            begin
                // floor(p / 2^FRAC_BITS), clamped to the 64-bit range
                if ((q_high == '0) || (q_high == '1))
                begin
                    product_next = full[Q_TOP:lorenz_pkg::FRAC_BITS];
                    ovf_next     = 1'b0;
                end
                else
                begin
                    product_next = full[FULL_WIDTH-1] ? lorenz_pkg::DP_MIN : lorenz_pkg::DP_MAX;
                    ovf_next     = 1'b1;
                end
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= M_IDLE;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            product_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
            ovf_reg     <= ovf_next;
            product_reg <= product_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        h_reg <= h_next;
        l_reg <= l_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.ovf     = ovf_reg;
    assign rsp.product = product_reg;

endmodule

// ===== rtl/lorenz_seq.sv =====
// Step sequencer: point registers, saturating adder and the Euler step schedule.
module lorenz_seq
#(
    parameter int WORD_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               restart,
    input  lorenz_pkg::cfg_t   cfg,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output lorenz_pkg::point_t res
);

    typedef logic signed [WORD_WIDTH-1:0]           word_t;
    typedef logic signed [lorenz_pkg::DP_WIDTH:0]   dp_wide_t;

    typedef struct packed {
        lorenz_pkg::dp_t value;
        logic            clip;
    } sat_t;

    typedef struct packed {
        word_t value;
        logic  clip;
    } word_sat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB_YX,
        S_MUL_DX,
        S_SUB_RZ,
        S_MUL_XR,
        S_MUL_XY,
        S_MUL_BZ,
        S_MUL_TX,
        S_MUL_TY,
        S_MUL_TZ,
        S_DONE
    } state_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam word_t WORD_ONE = lorenz_pkg::ONE_Q[WORD_WIDTH-1:0];

    function automatic sat_t add_sat(lorenz_pkg::dp_t a, lorenz_pkg::dp_t b, logic sub);
        dp_wide_t s;
        sat_t     r;
        if (sub)
        begin
            s = dp_wide_t'(a) - dp_wide_t'(b);
        end
        else
        begin
            s = dp_wide_t'(a) + dp_wide_t'(b);
        end
        if (s[lorenz_pkg::DP_WIDTH] != s[lorenz_pkg::DP_WIDTH-1])
        begin
            r.value = s[lorenz_pkg::DP_WIDTH] ? lorenz_pkg::DP_MIN : lorenz_pkg::DP_MAX;
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = s[lorenz_pkg::DP_WIDTH-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    function automatic word_sat_t clamp_word(lorenz_pkg::dp_t v);
        logic [lorenz_pkg::DP_WIDTH-WORD_WIDTH:0] upper;
        word_sat_t                                r;
        upper = v[lorenz_pkg::DP_WIDTH-1:WORD_WIDTH-1];
        if ((upper == '0) || (upper == '1))
        begin
            r.value = v[WORD_WIDTH-1:0];
            r.clip  = 1'b0;
        end
        else
        begin
            r.value = v[lorenz_pkg::DP_WIDTH-1] ? WORD_MIN : WORD_MAX;
            r.clip  = 1'b1;
        end
        return r;
    endfunction

    state_t               state_reg, state_next;
    logic                 wait_reg, wait_next;
    logic                 clip_reg, clip_next;
    word_t                cur_x_reg, cur_x_next;
    word_t                cur_y_reg, cur_y_next;
    word_t                cur_z_reg, cur_z_next;

    lorenz_pkg::dp_t      tmp_reg, tmp_next;
    lorenz_pkg::dp_t      dx_reg, dx_next;
    lorenz_pkg::dp_t      dy_reg, dy_next;
    lorenz_pkg::dp_t      dz_reg, dz_next;

    lorenz_pkg::dp_t      x_wide, y_wide, z_wide;
    lorenz_pkg::dp_t      alu_a, alu_b;
    logic                 alu_sub;
    sat_t                 alu_res;
    word_sat_t            word_res;
    word_sat_t            sx, sy, sz;
    logic                 mul_phase;

    lorenz_pkg::mul_req_t mul_req;
    lorenz_pkg::mul_rsp_t mul_rsp;

    lorenz_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_comb
    begin
        x_wide = lorenz_pkg::dp_t'(cur_x_reg);
        y_wide = lorenz_pkg::dp_t'(cur_y_reg);
        z_wide = lorenz_pkg::dp_t'(cur_z_reg);
        sx     = clamp_word(lorenz_pkg::dp_t'(signed'(cfg.start_x)));
        sy     = clamp_word(lorenz_pkg::dp_t'(signed'(cfg.start_y)));
        sz     = clamp_word(lorenz_pkg::dp_t'(signed'(cfg.start_z)));
    end

    assign mul_phase = (state_reg == S_MUL_DX) || (state_reg == S_MUL_XR) ||
                       (state_reg == S_MUL_XY) || (state_reg == S_MUL_BZ) ||
                       (state_reg == S_MUL_TX) || (state_reg == S_MUL_TY) ||
                       (state_reg == S_MUL_TZ);

    // operand routing for the shared adder and the multiplier
    always_comb
    begin
        alu_a     = y_wide;
        alu_b     = x_wide;
        alu_sub   = 1'b1;
        mul_req.a = x_wide;
        mul_req.b = y_wide;
        case (state_reg)
            S_SUB_RZ:
            begin
                alu_a = lorenz_pkg::dp_t'(cfg.rho);
                alu_b = z_wide;
            end
            S_MUL_DX:
            begin
                mul_req.a = lorenz_pkg::dp_t'(cfg.sigma);
                mul_req.b = tmp_reg;
            end
            S_MUL_XR:
            begin
                mul_req.b = tmp_reg;
                alu_a     = mul_rsp.product;
                alu_b     = y_wide;
            end
            S_MUL_BZ:
            begin
                mul_req.a = lorenz_pkg::dp_t'(cfg.beta);
                mul_req.b = z_wide;
                alu_a     = tmp_reg;
                alu_b     = mul_rsp.product;
            end
            S_MUL_TX:
            begin
                mul_req.a = lorenz_pkg::dp_t'(cfg.time_step);
                mul_req.b = dx_reg;
                alu_a     = x_wide;
                alu_b     = mul_rsp.product;
                alu_sub   = 1'b0;
            end
            S_MUL_TY:
            begin
                mul_req.a = lorenz_pkg::dp_t'(cfg.time_step);
                mul_req.b = dy_reg;
                alu_a     = y_wide;
                alu_b     = mul_rsp.product;
                alu_sub   = 1'b0;
            end
            S_MUL_TZ:
            begin
                mul_req.a = lorenz_pkg::dp_t'(cfg.time_step);
                mul_req.b = dz_reg;
                alu_a     = z_wide;
                alu_b     = mul_rsp.product;
                alu_sub   = 1'b0;
            end
            default:
            begin
            end
        endcase
        mul_req.start = mul_phase && !wait_reg;
        alu_res       = add_sat(alu_a, alu_b, alu_sub);
        word_res      = clamp_word(alu_res.value);
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        clip_next  = clip_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cur_z_next = cur_z_reg;
        tmp_next   = tmp_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;

        if (mul_req.start)
        begin
            wait_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (restart)
                    begin
                        cur_x_next = sx.value;
                        cur_y_next = sy.value;
                        cur_z_next = sz.value;
                        clip_next  = sx.clip | sy.clip | sz.clip;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        clip_next  = 1'b0;
                        state_next = S_SUB_YX;
                    end
                end
            end
            S_SUB_YX:
            begin
                tmp_next   = alu_res.value;
                clip_next  = clip_reg | alu_res.clip;
                state_next = S_MUL_DX;
            end
            S_SUB_RZ:
            begin
                tmp_next   = alu_res.value;
                clip_next  = clip_reg | alu_res.clip;
                state_next = S_MUL_XR;
            end
            S_MUL_DX, S_MUL_XR, S_MUL_XY, S_MUL_BZ, S_MUL_TX, S_MUL_TY, S_MUL_TZ:
            begin
                if (wait_reg && mul_rsp.done)
                begin
                    wait_next = 1'b0;
                    case (state_reg)
                        S_MUL_DX:
                        begin
                            dx_next    = mul_rsp.product;
                            clip_next  = clip_reg | mul_rsp.ovf;
                            state_next = S_SUB_RZ;
                        end
                        S_MUL_XR:
                        begin
                            dy_next    = alu_res.value;
                            clip_next  = clip_reg | mul_rsp.ovf | alu_res.clip;
                            state_next = S_MUL_XY;
                        end
                        S_MUL_XY:
                        begin
                            tmp_next   = mul_rsp.product;
                            clip_next  = clip_reg | mul_rsp.ovf;
                            state_next = S_MUL_BZ;
                        end
                        S_MUL_BZ:
                        begin
                            dz_next    = alu_res.value;
                            clip_next  = clip_reg | mul_rsp.ovf | alu_res.clip;
                            state_next = S_MUL_TX;
                        end
                        S_MUL_TX:
                        begin
                            // x is no longer read as an operand once its update lands
                            cur_x_next = word_res.value;
                            clip_next  = clip_reg | mul_rsp.ovf | alu_res.clip | word_res.clip;
                            state_next = S_MUL_TY;
                        end
                        S_MUL_TY:
                        begin
                            cur_y_next = word_res.value;
                            clip_next  = clip_reg | mul_rsp.ovf | alu_res.clip | word_res.clip;
                            state_next = S_MUL_TZ;
                        end
                        default:
                        begin
                            cur_z_next = word_res.value;
                            clip_next  = clip_reg | mul_rsp.ovf | alu_res.clip | word_res.clip;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            clip_reg  <= 1'b0;
            cur_x_reg <= WORD_ONE;
            cur_y_reg <= WORD_ONE;
            cur_z_reg <= WORD_ONE;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            clip_reg  <= clip_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            cur_z_reg <= cur_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
    end

    assign idle        = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.pos_x   = x_wide[lorenz_pkg::OUT_WIDTH-1:0];
    assign res.pos_y   = y_wide[lorenz_pkg::OUT_WIDTH-1:0];
    assign res.pos_z   = z_wide[lorenz_pkg::OUT_WIDTH-1:0];
    assign res.clipped = clip_reg;

endmodule
